// File: rtl/sfpp_pkg.sv
package sfpp_pkg;

	// Configuration register indexes
	localparam logic [2:0] CFG_VIEW_DISTANCE = 3'd0;
	localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd1;
	localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd2;
	localparam logic [2:0] CFG_ROW_PITCH     = 3'd3;
	localparam logic [2:0] CFG_DEPTH_STEP    = 3'd4;
	localparam logic [2:0] CFG_NEAR_PLANE    = 3'd5;
	localparam logic [2:0] CFG_FAR_PLANE     = 3'd6;

	// Reset values
	localparam logic [11:0] RST_VIEW_DISTANCE = 12'd320;
	localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [12:0] RST_ROW_PITCH     = 13'd640;
	localparam logic [8:0]  RST_DEPTH_STEP    = 9'd4;
	localparam logic [15:0] RST_NEAR_PLANE    = 16'd10;
	localparam logic [15:0] RST_FAR_PLANE     = 16'd2000;

	localparam logic [12:0] MAX_SCREEN = 13'd4096;
	localparam logic [15:0] DEPTH_MAX  = 16'hFFFF;

	// Quotient bits resolved per divider stage
	localparam int DIV_BITS = 3;

	typedef struct packed {
		logic signed [11:0] point_x;
		logic signed [11:0] point_y;
		logic [15:0]        point_z;
		logic [15:0]        point_color;
	} point_t;

	typedef struct packed {
		logic [15:0] new_depth;
		logic        visible;
		logic [11:0] screen_x;
		logic [11:0] screen_y;
		logic [23:0] pixel_index;
		logic [15:0] pixel_color;
	} result_t;

	// One divider lane: |numerator| / depth, 12 quotient bits plus overflow
	typedef struct packed {
		logic [28:0] rem;
		logic [11:0] quo;
		logic        neg;
		logic        ovf;
	} div_lane_t;

	typedef struct packed {
		logic [15:0] nz;
		logic [15:0] color;
		div_lane_t   lx;
		div_lane_t   ly;
	} div_pipe_t;

	// Three restoring steps, quotient bits top..top-2
	function automatic div_lane_t div_step3(div_lane_t l, logic [15:0] d, logic [3:0] top);
		div_lane_t   r;
		logic [28:0] sh;
		logic [3:0]  b;
		r = l;
		for (int i = 0; i < DIV_BITS; i++) begin
			b  = top - 4'(i);
			sh = 29'(d) << b;
			if (r.rem >= sh) begin
				r.rem    = r.rem - sh;
				r.quo[b] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/starfield_perspective_project_unit.sv
// Channel   Handshake            Payload
// -------   ------------------   -----------------------------------------
// point     start / busy         sfpp_pkg::point_t  (x, y, z, color)
// result    done (strobe)        sfpp_pkg::result_t (depth, vis, x, y, idx, color)
// config    cfg_we               cfg_index, cfg_data (16 bit)
//
// Nine-stage pipeline: one item per cycle. Depth update, four multipliers,
// numerator build, four divider stages of three quotient bits each, clip,
// then pixel index add. busy is never raised; there is no stall and the
// receiver takes every done. arst_n clears stage valids and loads the
// register reset values.
module starfield_perspective_project_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  sfpp_pkg::point_t    point,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                done,
	output sfpp_pkg::result_t   result
);

	// Configuration registers
	logic [11:0] vd_q;
	logic [12:0] sw_q, sh_q, pitch_q;
	logic [8:0]  step_q;
	logic [15:0] near_q, far_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_q    <= sfpp_pkg::RST_VIEW_DISTANCE;
			sw_q    <= sfpp_pkg::RST_SCREEN_WIDTH;
			sh_q    <= sfpp_pkg::RST_SCREEN_HEIGHT;
			pitch_q <= sfpp_pkg::RST_ROW_PITCH;
			step_q  <= sfpp_pkg::RST_DEPTH_STEP;
			near_q  <= sfpp_pkg::RST_NEAR_PLANE;
			far_q   <= sfpp_pkg::RST_FAR_PLANE;
		end else if (cfg_we) begin
			case (cfg_index)
				sfpp_pkg::CFG_VIEW_DISTANCE: vd_q    <= cfg_data[11:0];
				sfpp_pkg::CFG_SCREEN_WIDTH:  sw_q    <= cfg_data[12:0];
				sfpp_pkg::CFG_SCREEN_HEIGHT: sh_q    <= cfg_data[12:0];
				sfpp_pkg::CFG_ROW_PITCH:     pitch_q <= cfg_data[12:0];
				sfpp_pkg::CFG_DEPTH_STEP:    step_q  <= cfg_data[8:0];
				sfpp_pkg::CFG_NEAR_PLANE:    near_q  <= cfg_data;
				sfpp_pkg::CFG_FAR_PLANE:     far_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamped screen size and center
	logic [12:0] w_eff, h_eff;
	logic [11:0] cx, cy;
	assign w_eff = (sw_q > sfpp_pkg::MAX_SCREEN) ? sfpp_pkg::MAX_SCREEN : sw_q;
	assign h_eff = (sh_q > sfpp_pkg::MAX_SCREEN) ? sfpp_pkg::MAX_SCREEN : sh_q;
	assign cx    = w_eff[12:1];
	assign cy    = h_eff[12:1];

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Stage 1: depth step, wrap at near plane, saturate at max
	logic signed [17:0] nz_raw;
	logic [15:0]        nz_next;
	assign nz_raw = $signed({2'b00, point.point_z}) - $signed({{9{step_q[8]}}, step_q});

	always_comb begin
		if (nz_raw <= $signed({2'b00, near_q}))
			nz_next = far_q;
		else if (nz_raw > $signed({2'b00, sfpp_pkg::DEPTH_MAX}))
			nz_next = sfpp_pkg::DEPTH_MAX;
		else
			nz_next = nz_raw[15:0];
	end

	logic [15:0]        nz_s1, color_s1;
	logic signed [11:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		nz_s1    <= nz_next;
		color_s1 <= point.point_color;
		x_s1     <= point.point_x;
		y_s1     <= point.point_y;
	end

	// Stage 2: center times depth, view distance times coordinate
	logic [15:0]        nz_s2, color_s2;
	logic [27:0]        cxz_s2, cyz_s2;
	logic signed [24:0] vdx_s2, vdy_s2;

	always_ff @(posedge clk) begin
		nz_s2    <= nz_s1;
		color_s2 <= color_s1;
		cxz_s2   <= cx * nz_s1;
		cyz_s2   <= cy * nz_s1;
		vdx_s2   <= $signed({1'b0, vd_q}) * x_s1;
		vdy_s2   <= $signed({1'b0, vd_q}) * y_s1;
	end

	// Stage 3: signed numerators, magnitude, overflow past 12 quotient bits
	logic signed [29:0] numx, numy;
	logic [29:0]        magx, magy;
	sfpp_pkg::div_lane_t lx_init, ly_init;

	assign numx = $signed({2'b00, cxz_s2}) + 30'(vdx_s2);
	assign numy = $signed({2'b00, cyz_s2}) - 30'(vdy_s2);
	assign magx = numx[29] ? 30'(-numx) : 30'(numx);
	assign magy = numy[29] ? 30'(-numy) : 30'(numy);

	always_comb begin
		lx_init.rem = magx[28:0];
		lx_init.quo = '0;
		lx_init.neg = numx[29];
		lx_init.ovf = (magx[28:12] >= {1'b0, nz_s2});
		ly_init.rem = magy[28:0];
		ly_init.quo = '0;
		ly_init.neg = numy[29];
		ly_init.ovf = (magy[28:12] >= {1'b0, nz_s2});
	end

	sfpp_pkg::div_pipe_t d_s3, d_s4, d_s5, d_s6, d_s7;

	always_ff @(posedge clk) begin
		d_s3.nz    <= nz_s2;
		d_s3.color <= color_s2;
		d_s3.lx    <= lx_init;
		d_s3.ly    <= ly_init;
	end

	// Stages 4-7: restoring division, three quotient bits per stage
	always_ff @(posedge clk) begin
		d_s4.nz    <= d_s3.nz;
		d_s4.color <= d_s3.color;
		d_s4.lx    <= sfpp_pkg::div_step3(d_s3.lx, d_s3.nz, 4'd11);
		d_s4.ly    <= sfpp_pkg::div_step3(d_s3.ly, d_s3.nz, 4'd11);
		d_s5.nz    <= d_s4.nz;
		d_s5.color <= d_s4.color;
		d_s5.lx    <= sfpp_pkg::div_step3(d_s4.lx, d_s4.nz, 4'd8);
		d_s5.ly    <= sfpp_pkg::div_step3(d_s4.ly, d_s4.nz, 4'd8);
		d_s6.nz    <= d_s5.nz;
		d_s6.color <= d_s5.color;
		d_s6.lx    <= sfpp_pkg::div_step3(d_s5.lx, d_s5.nz, 4'd5);
		d_s6.ly    <= sfpp_pkg::div_step3(d_s5.ly, d_s5.nz, 4'd5);
		d_s7.nz    <= d_s6.nz;
		d_s7.color <= d_s6.color;
		d_s7.lx    <= sfpp_pkg::div_step3(d_s6.lx, d_s6.nz, 4'd2);
		d_s7.ly    <= sfpp_pkg::div_step3(d_s6.ly, d_s6.nz, 4'd2);
	end

	// Stage 8: clip; a negative quotient is on screen only when it truncates to zero
	// and the screen is not empty
	logic        visx, visy, vis;
	logic [11:0] sx, sy;

	always_comb begin
		if (d_s7.lx.neg)
			visx = !d_s7.lx.ovf && (d_s7.lx.quo == 12'd0) && (w_eff != 13'd0);
		else
			visx = !d_s7.lx.ovf && ({1'b0, d_s7.lx.quo} < w_eff);
		if (d_s7.ly.neg)
			visy = !d_s7.ly.ovf && (d_s7.ly.quo == 12'd0) && (h_eff != 13'd0);
		else
			visy = !d_s7.ly.ovf && ({1'b0, d_s7.ly.quo} < h_eff);
		vis = visx && visy && (d_s7.nz != 16'd0);
		sx  = (vis && !d_s7.lx.neg) ? d_s7.lx.quo : 12'd0;
		sy  = (vis && !d_s7.ly.neg) ? d_s7.ly.quo : 12'd0;
	end

	logic [15:0] nz_s8, color_s8;
	logic        vis_s8;
	logic [11:0] sx_s8, sy_s8;
	logic [24:0] row_s8;

	always_ff @(posedge clk) begin
		nz_s8    <= d_s7.nz;
		color_s8 <= vis ? d_s7.color : 16'd0;
		vis_s8   <= vis;
		sx_s8    <= sx;
		sy_s8    <= sy;
		row_s8   <= sy * pitch_q;
	end

	// Stage 9: pixel index and output register
	sfpp_pkg::result_t res_s9;

	always_ff @(posedge clk) begin
		res_s9.new_depth   <= nz_s8;
		res_s9.visible     <= vis_s8;
		res_s9.screen_x    <= sx_s8;
		res_s9.screen_y    <= sy_s8;
		res_s9.pixel_index <= row_s8[23:0] + 24'(sx_s8);
		res_s9.pixel_color <= color_s8;
	end

	assign done   = v_s9;
	assign result = res_s9;

	// Checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##9 done)
		else $error("item did not come out nine cycles after start");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.visible) |-> (result.screen_x == 12'd0 &&
		result.screen_y == 12'd0 && result.pixel_index == 24'd0 &&
		result.pixel_color == 16'd0))
		else $error("hidden point carries nonzero fields");

	a_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.visible) |-> ({1'b0, result.screen_x} < w_eff &&
		{1'b0, result.screen_y} < h_eff && result.new_depth != 16'd0))
		else $error("visible point outside the screen");

endmodule

// File: bench/starfield_perspective_project_unit_test.sv
module starfield_perspective_project_unit_test;

	import sfpp_pkg::*;

	// Index with no register behind it; writes to it must be dropped
	localparam logic [2:0] CFG_UNUSED = 3'd7;

	localparam int TARGET_ITEMS = 1950;
	localparam int QUIET_AFTER  = 1750;   // no idling past this many items
	localparam int STALL_LIMIT  = 2000;   // cycles with no handshake at all
	localparam int DRAIN_CYCLES = 12;     // pipeline is nine deep
	localparam int MAX_PRINTED  = 100;

	// Expected pixels and the projection that produces them
	class star_projection_check;
		logic [11:0]        view_dist;
		logic [12:0]        scr_w;
		logic [12:0]        scr_h;
		logic [12:0]        pitch;
		logic signed [8:0]  step;
		logic [15:0]        near;
		logic [15:0]        far;
		result_t            expected_pixels[$];
		int unsigned        item_ids[$];
		int unsigned        noted;
		int unsigned        mismatches;

		function new();
			view_dist  = RST_VIEW_DISTANCE;
			scr_w      = RST_SCREEN_WIDTH;
			scr_h      = RST_SCREEN_HEIGHT;
			pitch      = RST_ROW_PITCH;
			step       = RST_DEPTH_STEP;
			near       = RST_NEAR_PLANE;
			far        = RST_FAR_PLANE;
			noted      = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				CFG_VIEW_DISTANCE: view_dist = data[11:0];
				CFG_SCREEN_WIDTH:  scr_w     = data[12:0];
				CFG_SCREEN_HEIGHT: scr_h     = data[12:0];
				CFG_ROW_PITCH:     pitch     = data[12:0];
				CFG_DEPTH_STEP:    step      = data[8:0];
				CFG_NEAR_PLANE:    near      = data;
				CFG_FAR_PLANE:     far       = data;
				default: ;
			endcase
		endfunction

		// Depth step with wrap/saturate, then exact projection truncated toward zero
		function result_t project_point(point_t p);
			longint  x, y, z, nz, w, h, vd, sx, sy, idx;
			bit      vis;
			result_t r;
			x  = longint'($signed(p.point_x));
			y  = longint'($signed(p.point_y));
			z  = longint'(p.point_z);
			w  = (scr_w > MAX_SCREEN) ? longint'(MAX_SCREEN) : longint'(scr_w);
			h  = (scr_h > MAX_SCREEN) ? longint'(MAX_SCREEN) : longint'(scr_h);
			vd = longint'(view_dist);
			nz = z - longint'(step);
			if (nz <= longint'(near)) begin
				nz = longint'(far);
			end else if (nz > longint'(DEPTH_MAX)) begin
				nz = longint'(DEPTH_MAX);
			end
			sx  = 0;
			sy  = 0;
			vis = 1'b0;
			// zero depth only happens on a wrap to a far plane of zero
			if (nz > 0) begin
				sx  = ((w / 2) * nz + vd * x) / nz;
				sy  = ((h / 2) * nz - vd * y) / nz;
				vis = (sx >= 0) && (sx < w) && (sy >= 0) && (sy < h);
			end
			r = '0;
			r.new_depth = nz[15:0];
			if (vis) begin
				idx           = sx + sy * longint'(pitch);
				r.visible     = 1'b1;
				r.screen_x    = sx[11:0];
				r.screen_y    = sy[11:0];
				r.pixel_index = idx[23:0];
				r.pixel_color = p.point_color;
			end
			return r;
		endfunction

		function void note_point(point_t p);
			expected_pixels.push_back(project_point(p));
			item_ids.push_back(noted);
			noted++;
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction

		task report(string msg);
			if (mismatches < MAX_PRINTED) begin
				$display("MISMATCH: %s", msg);
			end
			mismatches++;
		endtask

		task check_pixel(result_t got);
			result_t     want;
			int unsigned id;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result with no item pending: %p", got));
				return;
			end
			want = expected_pixels.pop_front();
			id   = item_ids.pop_front();
			if (got.new_depth !== want.new_depth)
				report($sformatf("item %0d new_depth %0d, expected %0d",
					id, got.new_depth, want.new_depth));
			if (got.visible !== want.visible)
				report($sformatf("item %0d visible %b, expected %b",
					id, got.visible, want.visible));
			if (got.screen_x !== want.screen_x)
				report($sformatf("item %0d screen_x %0d, expected %0d",
					id, got.screen_x, want.screen_x));
			if (got.screen_y !== want.screen_y)
				report($sformatf("item %0d screen_y %0d, expected %0d",
					id, got.screen_y, want.screen_y));
			if (got.pixel_index !== want.pixel_index)
				report($sformatf("item %0d pixel_index %0d, expected %0d",
					id, got.pixel_index, want.pixel_index));
			if (got.pixel_color !== want.pixel_color)
				report($sformatf("item %0d pixel_color %h, expected %h",
					id, got.pixel_color, want.pixel_color));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	point_t      point;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        done;
	result_t     result;

	star_projection_check sb = new();

	logic [15:0] cfg_plan [CFG_VIEW_DISTANCE:CFG_FAR_PLANE];
	int          idle_pct;
	int          stall_cycles = 0;

	starfield_perspective_project_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point     (point),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results can't be held off: check every strobe
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_pixel(result);
		end
	end

	// Watchdog: give up after a long stretch with no handshake
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Leaves start high; the caller lowers it in the same step if nothing follows
	task automatic send_point(point_t p);
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		sb.note_point(p);
	endtask

	// Gap on the input side, with junk on the point bus
	task automatic idle(int cycles);
		start <= 1'b0;
		repeat (cycles) begin
			point <= point_t'({$urandom, $urandom});
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Registers only change with the pipeline empty
	task automatic apply_plan();
		drain();
		write_reg(CFG_UNUSED, 16'($urandom));
		for (int i = CFG_VIEW_DISTANCE; i <= CFG_FAR_PLANE; i++) begin
			write_reg(3'(i), cfg_plan[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [11:0] random_coord();
		case ($urandom_range(0, 3))
			0, 1: return 12'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return 12'h800;
					1: return 12'h7FF;
					2: return 12'h000;
					default: return 12'hFFF;
				endcase
			end
			default: return 12'($urandom_range(0, 255) - 128);
		endcase
	endfunction

	// Depth biased toward the wrap threshold and the saturation end
	function automatic point_t random_point();
		point_t p;
		longint wrap_z;
		case ($urandom_range(0, 9))
			3, 4: begin
				wrap_z = longint'(sb.near) + longint'(sb.step)
					+ longint'($urandom_range(0, 4)) - 2;
				if (wrap_z < 0) wrap_z = 0;
				if (wrap_z > 65535) wrap_z = 65535;
				p.point_z = wrap_z[15:0];
			end
			5, 6: p.point_z = 16'($urandom_range(1, 4000));
			7: p.point_z = 16'($urandom_range(65000, 65535));
			8: p.point_z = 16'($urandom_range(1, 64));
			default: p.point_z = 16'($urandom);
		endcase
		p.point_x     = random_coord();
		p.point_y     = random_coord();
		p.point_color = 16'($urandom);
		return p;
	endfunction

	task automatic run_random(int count);
		for (int n = 0; n < count; n++) begin
			if (sb.noted < QUIET_AFTER && $urandom_range(0, 99) < idle_pct) begin
				idle($urandom_range(1, 5));
			end
			send_point(random_point());
		end
	endtask

	function automatic logic [15:0] pick_size();
		case ($urandom_range(0, 11))
			0: return 16'd2;
			1: return 16'd4096;
			2: return 16'd640;
			3: return 16'($urandom_range(4097, 8191));
			4: return 16'($urandom_range(0, 1));
			5: return 16'($urandom);
			default: return 16'($urandom_range(2, 4096));
		endcase
	endfunction

	task automatic random_plan();
		case ($urandom_range(0, 9))
			0: cfg_plan[CFG_VIEW_DISTANCE] = 16'd1;
			1: cfg_plan[CFG_VIEW_DISTANCE] = 16'd4095;
			2: cfg_plan[CFG_VIEW_DISTANCE] = 16'($urandom);
			3, 4: cfg_plan[CFG_VIEW_DISTANCE] = 16'($urandom_range(1, 600));
			default: cfg_plan[CFG_VIEW_DISTANCE] = 16'($urandom_range(1, 4095));
		endcase
		cfg_plan[CFG_SCREEN_WIDTH]  = pick_size();
		cfg_plan[CFG_SCREEN_HEIGHT] = pick_size();
		case ($urandom_range(0, 7))
			0: cfg_plan[CFG_ROW_PITCH] = 16'd1;
			1: cfg_plan[CFG_ROW_PITCH] = 16'd4096;
			2: cfg_plan[CFG_ROW_PITCH] = 16'($urandom);
			default: cfg_plan[CFG_ROW_PITCH] = 16'($urandom_range(1, 4096));
		endcase
		// upper bits beyond the 9-bit step are don't-care
		case ($urandom_range(0, 5))
			0: cfg_plan[CFG_DEPTH_STEP] = {7'($urandom), 9'h101};
			1: cfg_plan[CFG_DEPTH_STEP] = {7'($urandom), 9'h0FF};
			2: cfg_plan[CFG_DEPTH_STEP] = 16'd0;
			default: cfg_plan[CFG_DEPTH_STEP] = 16'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: cfg_plan[CFG_NEAR_PLANE] = 16'd1;
			1: cfg_plan[CFG_NEAR_PLANE] = 16'hFFFF;
			2: cfg_plan[CFG_NEAR_PLANE] = 16'($urandom);
			default: cfg_plan[CFG_NEAR_PLANE] = 16'($urandom_range(1, 2000));
		endcase
		case ($urandom_range(0, 6))
			0: cfg_plan[CFG_FAR_PLANE] = 16'd1;
			1: cfg_plan[CFG_FAR_PLANE] = 16'hFFFF;
			2: cfg_plan[CFG_FAR_PLANE] = 16'd0;
			default: cfg_plan[CFG_FAR_PLANE] = 16'($urandom);
		endcase
	endtask

	task automatic reset_plan();
		cfg_plan[CFG_VIEW_DISTANCE] = 16'(RST_VIEW_DISTANCE);
		cfg_plan[CFG_SCREEN_WIDTH]  = 16'(RST_SCREEN_WIDTH);
		cfg_plan[CFG_SCREEN_HEIGHT] = 16'(RST_SCREEN_HEIGHT);
		cfg_plan[CFG_ROW_PITCH]     = 16'(RST_ROW_PITCH);
		cfg_plan[CFG_DEPTH_STEP]    = 16'(RST_DEPTH_STEP);
		cfg_plan[CFG_NEAR_PLANE]    = RST_NEAR_PLANE;
		cfg_plan[CFG_FAR_PLANE]     = RST_FAR_PLANE;
	endtask

	// Special register settings, each followed by a short random burst
	task automatic corner_phases();
		// far plane of zero: every wrapped point lands at depth zero
		reset_plan();
		cfg_plan[CFG_NEAR_PLANE] = 16'hFFFF;
		cfg_plan[CFG_FAR_PLANE]  = 16'd0;
		apply_plan();
		run_random(40);
		// zero view distance, written with junk in the unused upper bits
		reset_plan();
		cfg_plan[CFG_VIEW_DISTANCE] = 16'hF000;
		apply_plan();
		run_random(40);
		// oversized screen and pitch: clip at 4096, index wraps at 24 bits
		cfg_plan[CFG_VIEW_DISTANCE] = 16'd4095;
		cfg_plan[CFG_SCREEN_WIDTH]  = 16'd8191;
		cfg_plan[CFG_SCREEN_HEIGHT] = 16'd4097;
		cfg_plan[CFG_ROW_PITCH]     = 16'd8191;
		cfg_plan[CFG_NEAR_PLANE]    = 16'd1;
		apply_plan();
		run_random(40);
		// zero-width screen
		reset_plan();
		cfg_plan[CFG_SCREEN_WIDTH]  = 16'd0;
		apply_plan();
		run_random(30);
		// odd sizes, center rounds down
		cfg_plan[CFG_SCREEN_WIDTH]  = 16'd1;
		cfg_plan[CFG_SCREEN_HEIGHT] = 16'd3;
		cfg_plan[CFG_VIEW_DISTANCE] = 16'd1;
		apply_plan();
		run_random(30);
		// moving away at a step of -255: depth saturates
		reset_plan();
		cfg_plan[CFG_DEPTH_STEP] = 16'h0101;
		cfg_plan[CFG_NEAR_PLANE] = 16'd1;
		cfg_plan[CFG_FAR_PLANE]  = 16'hFFFF;
		apply_plan();
		run_random(40);
		// low extremes of every register
		cfg_plan[CFG_VIEW_DISTANCE] = 16'd1;
		cfg_plan[CFG_SCREEN_WIDTH]  = 16'd2;
		cfg_plan[CFG_SCREEN_HEIGHT] = 16'd2;
		cfg_plan[CFG_ROW_PITCH]     = 16'd1;
		cfg_plan[CFG_DEPTH_STEP]    = 16'h00FF;
		cfg_plan[CFG_NEAR_PLANE]    = 16'd1;
		cfg_plan[CFG_FAR_PLANE]     = 16'd1;
		apply_plan();
		run_random(40);
		// high extremes
		cfg_plan[CFG_VIEW_DISTANCE] = 16'd4095;
		cfg_plan[CFG_SCREEN_WIDTH]  = 16'd4096;
		cfg_plan[CFG_SCREEN_HEIGHT] = 16'd4096;
		cfg_plan[CFG_ROW_PITCH]     = 16'd4096;
		cfg_plan[CFG_DEPTH_STEP]    = 16'hFF01;
		cfg_plan[CFG_NEAR_PLANE]    = 16'hFFFF;
		cfg_plan[CFG_FAR_PLANE]     = 16'hFFFF;
		apply_plan();
		run_random(40);
	endtask

	// Reset settings: screen edges, truncation toward zero, wrap boundary
	task automatic directed_points();
		send_point(point_t'{12'sd0,     12'sd0,    16'd1004,  16'hFFFF});
		send_point(point_t'{12'sd319,   12'sd0,    16'd324,   16'hAAAA});
		send_point(point_t'{12'sd320,   12'sd0,    16'd324,   16'h5555});
		send_point(point_t'{-12'sd320,  12'sd0,    16'd324,   16'h1234});
		send_point(point_t'{-12'sd321,  12'sd0,    16'd324,   16'h4321});
		send_point(point_t'{12'sd0,     12'sd240,  16'd324,   16'h00FF});
		send_point(point_t'{12'sd0,    -12'sd239,  16'd324,   16'hFF00});
		send_point(point_t'{12'sd0,    -12'sd240,  16'd324,   16'h0F0F});
		send_point(point_t'{12'sd0,     12'sd241,  16'd324,   16'hF0F0});
		send_point(point_t'{-12'sd1001, 12'sd0,    16'd1004,  16'h8001});
		send_point(point_t'{12'sd0,     12'sd751,  16'd1004,  16'h7FFE});
		send_point(point_t'{12'sd800,   12'sd800,  16'd14,    16'h0000});
		send_point(point_t'{12'sd0,     12'sd0,    16'd15,    16'hFFFF});
		send_point(point_t'{12'sd0,     12'sd0,    16'd0,     16'h0001});
		send_point(point_t'{12'sd0,     12'sd0,    16'd1,     16'h8000});
		send_point(point_t'{12'h7FF,    12'h7FF,   16'hFFFF,  16'hFFFF});
		send_point(point_t'{12'h800,    12'h800,   16'hFFFF,  16'h0000});
		send_point(point_t'{12'h7FF,    12'h800,   16'd20,    16'hAAAA});
		send_point(point_t'{12'h800,    12'h7FF,   16'd3,     16'h5555});
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		point     <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_VIEW_DISTANCE;
		cfg_data  <= '0;
		idle_pct  = 20;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_points();
		corner_phases();

		// Random settings, each with its own idling density
		while (sb.noted < TARGET_ITEMS) begin
			random_plan();
			apply_plan();
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
			run_random(100);
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/sfpp_pkg.sv
rtl/starfield_perspective_project_unit.sv
bench/starfield_perspective_project_unit_test.sv
